### design/assert_macros.svh
// assertion macros used by mlfq_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, disabled while reset is low
`define MLFQ_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// expression that must never hold
`define MLFQ_ASSERT_NEVER(label, clk, rstn, expr, msg) \
  `MLFQ_ASSERT(label, clk, rstn, !(expr), msg)

`endif

### design/mlfq_pkg.sv
// shared types, codes and constants of the mlfq task scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mlfq_pkg;

  localparam int DEF_TASK_SLOTS = 16;
  localparam int QW             = 16;
  localparam int IDW            = 8;
  localparam int CFG_IDX_W      = 2;

  localparam logic [QW-1:0] QHIGH_RST = 16'd100;
  localparam logic [QW-1:0] QMID_RST  = 16'd300;
  localparam logic [QW-1:0] QLOW_RST  = 16'd600;

  localparam logic [1:0] PRIO_MAX = 2'd2;
  localparam logic [1:0] PRIO_ANY = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_HALT = 2'd3;

  // item kinds
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_EXIT   = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QHIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QMID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QLOW  = 2'd2;

  typedef enum logic [1:0] {RD_RUN, RD_FIRST, RD_NEXTQ} rd_sel_t;
  typedef enum logic [1:0] {WA_CAND, WA_RUN, WA_PTR} wa_sel_t;
  typedef enum logic [1:0] {ND_CAND, ND_FIRST, ND_NEXTQ} nd_sel_t;
  typedef enum logic [1:0] {RUN_CAND, RUN_FIRST, RUN_BEST} run_sel_t;
  typedef enum logic [1:0] {SRC_NEW, SRC_RAM, SRC_ZERO} src_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load_in;
    rd_sel_t  rd_sel;
    logic     ptr_ld;
    logic     ptr_first;
    logic     first_ld;
    logic     cand_inc;
    wa_sel_t  wa_sel;
    logic     we_id;
    logic     we_prio;
    logic     we_ticks;
    logic     we_next;
    nd_sel_t  nd_sel;
    logic     tick_upd;
    logic     set_used;
    logic     clr_used;
    logic     run_ld;
    run_sel_t run_sel;
    logic     best_init;
    logic     scan_step;
    logic     set_halt;
    logic     resp;
    logic [1:0] resp_status;
    src_t     resp_src;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic halted;
    logic run_valid;
    logic cand_free;
    logic cand_last;
    logic next_is_run;
    logic next_is_first;
  } sts_t;

endpackage

`default_nettype wire

### design/mlfq_task_scheduler.sv
// top level of the three-level feedback queue task scheduler
// depends on mlfq_pkg, mlfq_ctrl, mlfq_dp
//
// One item at a time: an item is taken when start is high and busy is low,
// and its single result shows on the out_ ports for one cycle with out_valid.
// The result can't be held off. The wait from accept to out_valid grows
// with the walk: create walks the free bits up to the lowest free slot,
// exit walks the ring of tasks to the running task's predecessor, and tick
// scans the whole ring; each ring hop is one read of the slot memories,
// which have a single read port.
// busy drops in the cycle the result appears, so the next item can go in then.
`timescale 1ns / 1ps
`default_nettype none

module mlfq_task_scheduler #(
  parameter int TASK_SLOTS = mlfq_pkg::DEF_TASK_SLOTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_kind,
  input  wire logic [mlfq_pkg::IDW-1:0]        in_new_task_id,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [3:0]                           out_task_slot,
  output logic [mlfq_pkg::IDW-1:0]             out_task_id,
  output logic [1:0]                           out_task_priority,
  input  wire logic                            cfg_we,
  input  wire logic [mlfq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mlfq_pkg::QW-1:0]         cfg_data
);
  import mlfq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  mlfq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_kind(in_kind),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  // slot store and result register
  mlfq_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_new_task_id(in_new_task_id),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .sts(sts),
    .out_valid(out_valid), .out_status(out_status), .out_task_slot(out_task_slot),
    .out_task_id(out_task_id), .out_task_priority(out_task_priority)
  );

endmodule

`default_nettype wire

### design/mlfq_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### design/mlfq_ctrl.sv
// controller state machine of the mlfq task scheduler
// depends on mlfq_pkg
`timescale 1ns / 1ps
`default_nettype none

module mlfq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    in_kind,
  input  wire mlfq_pkg::sts_t sts,
  output mlfq_pkg::cmd_t     cmd,
  output logic               busy
);
  import mlfq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_C_FIND, S_C_WR, S_C_LINK, S_C_LINK2,
    S_E_RD, S_E_CHK, S_E_WALK, S_E_UNLINK,
    S_T_RD, S_T_UPD, S_T_START, S_T_SCAN, S_T_DONE,
    S_READ_RUN, S_RESP
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] st_r, st_nxt;
  src_t       src_r, src_nxt;

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    src_nxt   = src_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          if (sts.halted) begin
            st_nxt = ST_HALT; src_nxt = SRC_ZERO; state_nxt = S_RESP;
          end else begin
            case (in_kind)
              KIND_CREATE: state_nxt = S_C_FIND;
              KIND_EXIT, KIND_TICK: begin
                if (!sts.run_valid) begin
                  st_nxt = ST_NONE; src_nxt = SRC_ZERO; state_nxt = S_RESP;
                end else begin
                  state_nxt = (in_kind == KIND_EXIT) ? S_E_RD : S_T_RD;
                end
              end
              default: begin
                if (sts.run_valid) begin
                  state_nxt = S_READ_RUN;
                end else begin
                  st_nxt = ST_OK; src_nxt = SRC_ZERO; state_nxt = S_RESP;
                end
              end
            endcase
          end
        end
      end
      // walk the free bits for the lowest free slot
      S_C_FIND: begin
        if (sts.cand_free) begin
          state_nxt = S_C_WR;
        end else if (sts.cand_last) begin
          st_nxt = ST_FULL; src_nxt = SRC_ZERO; state_nxt = S_RESP;
        end else begin
          cmd.cand_inc = 1'b1;
        end
      end
      S_C_WR: begin
        cmd.wa_sel   = WA_CAND;
        cmd.we_id    = 1'b1;
        cmd.we_prio  = 1'b1;
        cmd.we_ticks = 1'b1;
        cmd.set_used = 1'b1;
        st_nxt       = ST_OK;
        src_nxt      = SRC_NEW;
        if (!sts.run_valid) begin
          cmd.we_next = 1'b1;
          cmd.nd_sel  = ND_CAND;
          cmd.run_ld  = 1'b1;
          cmd.run_sel = RUN_CAND;
          state_nxt   = S_RESP;
        end else begin
          cmd.rd_sel = RD_RUN;
          state_nxt  = S_C_LINK;
        end
      end
      S_C_LINK: begin
        cmd.wa_sel  = WA_CAND;
        cmd.we_next = 1'b1;
        cmd.nd_sel  = ND_NEXTQ;
        state_nxt   = S_C_LINK2;
      end
      S_C_LINK2: begin
        cmd.wa_sel  = WA_RUN;
        cmd.we_next = 1'b1;
        cmd.nd_sel  = ND_CAND;
        state_nxt   = S_RESP;
      end
      // exit: find the predecessor of the running task and unlink it, or halt on the last task
      S_E_RD: begin
        cmd.rd_sel = RD_RUN;
        state_nxt  = S_E_CHK;
      end
      S_E_CHK: begin
        if (sts.next_is_run) begin
          cmd.set_halt = 1'b1;
          st_nxt = ST_HALT; src_nxt = SRC_ZERO; state_nxt = S_RESP;
        end else begin
          cmd.first_ld = 1'b1;
          cmd.rd_sel   = RD_NEXTQ;
          cmd.ptr_ld   = 1'b1;
          state_nxt    = S_E_WALK;
        end
      end
      S_E_WALK: begin
        if (sts.next_is_run) begin
          state_nxt = S_E_UNLINK;
        end else begin
          cmd.rd_sel = RD_NEXTQ;
          cmd.ptr_ld = 1'b1;
        end
      end
      S_E_UNLINK: begin
        cmd.wa_sel   = WA_PTR;
        cmd.we_next  = 1'b1;
        cmd.nd_sel   = ND_FIRST;
        cmd.clr_used = 1'b1;
        cmd.run_ld   = 1'b1;
        cmd.run_sel  = RUN_FIRST;
        state_nxt    = S_READ_RUN;
      end
      // tick: update quantum, then scan the ring
      S_T_RD: begin
        cmd.rd_sel = RD_RUN;
        state_nxt  = S_T_UPD;
      end
      S_T_UPD: begin
        cmd.wa_sel    = WA_RUN;
        cmd.we_prio   = 1'b1;
        cmd.we_ticks  = 1'b1;
        cmd.tick_upd  = 1'b1;
        cmd.first_ld  = 1'b1;
        cmd.best_init = 1'b1;
        state_nxt     = S_T_START;
      end
      S_T_START: begin
        cmd.rd_sel    = RD_FIRST;
        cmd.ptr_ld    = 1'b1;
        cmd.ptr_first = 1'b1;
        state_nxt     = S_T_SCAN;
      end
      S_T_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.next_is_first) begin
          state_nxt = S_T_DONE;
        end else begin
          cmd.rd_sel = RD_NEXTQ;
          cmd.ptr_ld = 1'b1;
        end
      end
      S_T_DONE: begin
        cmd.run_ld  = 1'b1;
        cmd.run_sel = RUN_BEST;
        state_nxt   = S_READ_RUN;
      end
      S_READ_RUN: begin
        cmd.rd_sel = RD_RUN;
        st_nxt     = ST_OK;
        src_nxt    = SRC_RAM;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        cmd.resp        = 1'b1;
        cmd.resp_status = st_r;
        cmd.resp_src    = src_r;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
      src_r   <= SRC_ZERO;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      src_r   <= src_nxt;
    end
  end

endmodule

`default_nettype wire

### design/mlfq_dp.sv
// datapath of the mlfq task scheduler: slot memories, pointers, result register
// depends on mlfq_pkg and mlfq_ram
`timescale 1ns / 1ps
`default_nettype none

module mlfq_dp #(
  parameter int TASK_SLOTS = mlfq_pkg::DEF_TASK_SLOTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mlfq_pkg::cmd_t                  cmd,
  input  wire logic [mlfq_pkg::IDW-1:0]        in_new_task_id,
  input  wire logic                            cfg_we,
  input  wire logic [mlfq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mlfq_pkg::QW-1:0]         cfg_data,
  output mlfq_pkg::sts_t                       sts,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [3:0]                           out_task_slot,
  output logic [mlfq_pkg::IDW-1:0]             out_task_id,
  output logic [1:0]                           out_task_priority
);
  import mlfq_pkg::*;

  localparam int SLOT_W = $clog2(TASK_SLOTS);

  logic [QW-1:0]         qh_r, qm_r, ql_r;
  logic [TASK_SLOTS-1:0] used_r;
  logic                  run_valid_r, halted_r;
  logic [SLOT_W-1:0]     run_r, cand_r, ptr_r, first_r, best_r;
  logic [1:0]            bestp_r;
  logic [IDW-1:0]        id_in_r;

  logic [SLOT_W-1:0]     rd_addr, wr_addr, next_wd, next_q;
  logic [IDW-1:0]        id_q;
  logic [1:0]            prio_q, prio_wd, np;
  logic [QW-1:0]         ticks_q, ticks_wd, nt;
  logic [SLOT_W-1:0]     out_slot;
  logic [SLOT_W+3:0]     slot_ext;

  function automatic logic [QW-1:0] reload_for(input logic [1:0] p, input logic [QW-1:0] h,
                                              input logic [QW-1:0] m, input logic [QW-1:0] l);
    case (p)
      2'd0:    reload_for = h;
      2'd1:    reload_for = m;
      default: reload_for = l;
    endcase
  endfunction

  // address and write data selection
  always_comb begin
    case (cmd.rd_sel)
      RD_RUN:   rd_addr = run_r;
      RD_FIRST: rd_addr = first_r;
      RD_NEXTQ: rd_addr = next_q;
      default:  rd_addr = run_r;
    endcase
    case (cmd.wa_sel)
      WA_CAND: wr_addr = cand_r;
      WA_RUN:  wr_addr = run_r;
      WA_PTR:  wr_addr = ptr_r;
      default: wr_addr = cand_r;
    endcase
    case (cmd.nd_sel)
      ND_CAND:  next_wd = cand_r;
      ND_FIRST: next_wd = first_r;
      ND_NEXTQ: next_wd = next_q;
      default:  next_wd = cand_r;
    endcase
  end

  // quantum update on a tick, or the initial quantum for a new task
  always_comb begin
    np = prio_q;
    nt = ticks_q - 16'd1;
    if (ticks_q <= 16'd1) begin
      if (prio_q < PRIO_MAX) begin
        np = prio_q + 2'd1;
      end
      nt = reload_for(np, qh_r, qm_r, ql_r);
    end
    prio_wd  = cmd.tick_upd ? np : 2'd0;
    ticks_wd = cmd.tick_upd ? nt : qh_r;
  end

  mlfq_ram #(.WIDTH(IDW), .DEPTH(TASK_SLOTS)) u_id_ram (
    .clk(clk), .we(cmd.we_id), .waddr(wr_addr), .wdata(id_in_r),
    .raddr(rd_addr), .rdata(id_q)
  );
  mlfq_ram #(.WIDTH(2), .DEPTH(TASK_SLOTS)) u_prio_ram (
    .clk(clk), .we(cmd.we_prio), .waddr(wr_addr), .wdata(prio_wd),
    .raddr(rd_addr), .rdata(prio_q)
  );
  mlfq_ram #(.WIDTH(QW), .DEPTH(TASK_SLOTS)) u_ticks_ram (
    .clk(clk), .we(cmd.we_ticks), .waddr(wr_addr), .wdata(ticks_wd),
    .raddr(rd_addr), .rdata(ticks_q)
  );
  mlfq_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_SLOTS)) u_next_ram (
    .clk(clk), .we(cmd.we_next), .waddr(wr_addr), .wdata(next_wd),
    .raddr(rd_addr), .rdata(next_q)
  );

  // status to the controller
  always_comb begin
    sts.halted        = halted_r;
    sts.run_valid     = run_valid_r;
    sts.cand_free     = !used_r[cand_r];
    sts.cand_last     = (cand_r == SLOT_W'(TASK_SLOTS - 1));
    sts.next_is_run   = (next_q == run_r);
    sts.next_is_first = (next_q == first_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qh_r        <= QHIGH_RST;
      qm_r        <= QMID_RST;
      ql_r        <= QLOW_RST;
      used_r      <= '0;
      run_valid_r <= 1'b0;
      run_r       <= '0;
      halted_r    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QHIGH: qh_r <= cfg_data;
          CFG_QMID:  qm_r <= cfg_data;
          CFG_QLOW:  ql_r <= cfg_data;
          default:   ;
        endcase
      end
      if (cmd.set_used) begin
        used_r[cand_r] <= 1'b1;
      end
      if (cmd.clr_used) begin
        used_r[run_r] <= 1'b0;
      end
      if (cmd.run_ld) begin
        case (cmd.run_sel)
          RUN_CAND: begin
            run_r       <= cand_r;
            run_valid_r <= 1'b1;
          end
          RUN_FIRST: run_r <= first_r;
          RUN_BEST:  run_r <= best_r;
          default:   run_r <= run_r;
        endcase
      end
      if (cmd.set_halt) begin
        halted_r <= 1'b1;
      end
      out_valid <= cmd.resp;
    end
  end

  // working pointers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      id_in_r <= in_new_task_id;
      cand_r  <= '0;
    end else if (cmd.cand_inc) begin
      cand_r <= cand_r + 1'b1;
    end
    if (cmd.ptr_ld) begin
      ptr_r <= cmd.ptr_first ? first_r : next_q;
    end
    if (cmd.first_ld) begin
      first_r <= next_q;
    end
    if (cmd.best_init) begin
      bestp_r <= PRIO_ANY;
    end else if (cmd.scan_step && (prio_q < bestp_r)) begin
      bestp_r <= prio_q;
      best_r  <= ptr_r;
    end
  end

  // result register
  always_comb begin
    out_slot = (cmd.resp_src == SRC_NEW) ? cand_r : run_r;
    slot_ext = {4'b0000, out_slot};
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_status <= cmd.resp_status;
      if (cmd.resp_status != ST_OK || cmd.resp_src == SRC_ZERO) begin
        out_task_slot     <= 4'd0;
        out_task_id       <= '0;
        out_task_priority <= 2'd0;
      end else if (cmd.resp_src == SRC_NEW) begin
        out_task_slot     <= slot_ext[3:0];
        out_task_id       <= id_in_r;
        out_task_priority <= 2'd0;
      end else begin
        out_task_slot     <= slot_ext[3:0];
        out_task_id       <= id_q;
        out_task_priority <= prio_q;
      end
    end
  end

endmodule

`default_nettype wire

### design/mlfq_checker.sv
// port-level checks of the mlfq task scheduler, bound to the top level
// depends on mlfq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mlfq_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     out_valid,
  input wire logic [1:0]               out_status,
  input wire logic [3:0]               out_task_slot,
  input wire logic [mlfq_pkg::IDW-1:0] out_task_id,
  input wire logic [1:0]               out_task_priority
);
  import mlfq_pkg::*;

  // an accepted item keeps the block busy
  `MLFQ_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept without busy")

  // one item yields one result, never two in a row
  `MLFQ_ASSERT(a_single_result, clk, rst_n, out_valid |=> !out_valid, "back to back results")

  // error results carry zero fields
  `MLFQ_ASSERT(a_err_zero, clk, rst_n, (out_valid && out_status != ST_OK) |-> (out_task_slot == 4'd0 && out_task_id == '0 && out_task_priority == 2'd0), "nonzero fields on error")

  // priority never passes the lowest level
  `MLFQ_ASSERT_NEVER(a_prio_range, clk, rst_n, out_valid && out_task_priority > PRIO_MAX, "bad priority")

endmodule

bind mlfq_task_scheduler mlfq_checker u_mlfq_checker (.*);

`default_nettype wire
